FILE: rtl/fdd_pkg.sv
// Package for the flip-dot frame difference engine.
// Holds the panel geometry, the operation codes and the column result type.
// It has no dependencies of its own.
package fdd_pkg;

  // Panel geometry.
  localparam int unsigned PanelWidth  = 32;
  localparam int unsigned PanelHeight = 8;

  // Width of a column index, at least one bit.
  localparam int unsigned ColW = (PanelWidth > 1) ? $clog2(PanelWidth) : 1;

  // Width of the output fields.
  localparam int unsigned OutColW  = 6;
  localparam int unsigned OutWordW = 32;

  // Operation codes.
  typedef logic [1:0] opcode_t;
  localparam opcode_t OpDraw   = 2'd0;
  localparam opcode_t OpClear  = 2'd1;
  localparam opcode_t OpRender = 2'd2;
  localparam opcode_t OpWipe   = 2'd3;

  // One column word, one bit per row.
  typedef logic [PanelHeight-1:0] col_word_t;

  // Result of the shared column unit.
  typedef struct packed {
    col_word_t chg;
    col_word_t dots;
  } col_result_t;

endpackage

FILE: rtl/fdd_col_unit.sv
// Shared column unit of the flip-dot frame difference engine.
// Works out the flip mask and the new dot values of one column per cycle.
// Depends on fdd_pkg.
module fdd_col_unit (
  input  logic                wipe_i,
  input  fdd_pkg::col_word_t  drawing_i,
  input  fdd_pkg::col_word_t  shown_i,
  output fdd_pkg::col_result_t result_o
);
  import fdd_pkg::*;

  // A wipe flips every row to dark; a render flips only the rows that differ.
  always_comb begin
    if (wipe_i) begin
      result_o.chg  = '1;
      result_o.dots = '0;
    end else begin
      result_o.chg  = drawing_i ^ shown_i;
      result_o.dots = drawing_i;
    end
  end

endmodule

FILE: rtl/flip_dot_frame_diff_engine_core.sv
// Top level of the flip-dot frame difference engine.
// Holds the drawing and shown frames, the column sequencer and the output register.
// Depends on fdd_pkg and fdd_col_unit.
//
// Draw and clear items are accepted without stalling the input and produce no transfer on the
// output. A render or wipe walks the panel one column per cycle through the shared column
// unit, as long as the output register is free or being emptied. The walk starts on the
// cycle after the input transfer and covers all PanelWidth columns; the input stalls for
// the whole walk. Each column leaves as one output transfer from a single output
// register, and the next item can be accepted while the final column is still waiting
// to be taken.
module flip_dot_frame_diff_engine_core (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // Input channel.
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  fdd_pkg::opcode_t       opcode_i,
  input  logic signed [6:0]      x_pos_i,
  input  logic signed [5:0]      y_pos_i,
  input  logic                   dot_color_i,
  // Output channel.
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [5:0]             column_index_o,
  output logic [31:0]            change_mask_o,
  output logic [31:0]            column_dots_o,
  output logic                   last_column_o
);
  import fdd_pkg::*;

  localparam int unsigned RowW = (PanelHeight > 1) ? $clog2(PanelHeight) : 1;

  // Sequencer states.
  localparam logic StIdle = 1'b0;
  localparam logic StWalk = 1'b1;

  logic             state_q, state_d;
  logic [ColW-1:0]  col_q, col_d;
  logic             wipe_q;

  col_word_t drawing_q [PanelWidth];
  col_word_t shown_q   [PanelWidth];

  logic              out_valid_q;
  logic [OutColW-1:0] out_col_q;
  col_word_t         out_chg_q;
  col_word_t         out_dots_q;
  logic              out_last_q;
  logic              out_wipe_q;

  logic        in_xfer;
  logic        draw_hit;
  logic        load;
  logic        col_last;
  col_result_t col_res;

  // Input transfer and the on-panel check of a draw.
  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign draw_hit   = ($unsigned(x_pos_i) < 7'(PanelWidth)) &&
                      ($unsigned(y_pos_i) < 6'(PanelHeight));

  // The walk advances whenever the output register is free or being emptied.
  assign load     = (state_q == StWalk) && (!out_valid_q || !out_stall_i);
  assign col_last = (col_q == ColW'(PanelWidth - 1));

  fdd_col_unit u_col_unit (
    .wipe_i    (wipe_q),
    .drawing_i (drawing_q[col_q]),
    .shown_i   (shown_q[col_q]),
    .result_o  (col_res)
  );

  // Next state of the sequencer.
  always_comb begin
    state_d = state_q;
    col_d   = col_q;
    case (state_q)
      StIdle: begin
        if (in_xfer && (opcode_i == OpRender || opcode_i == OpWipe)) begin
          state_d = StWalk;
          col_d   = '0;
        end
      end
      StWalk: begin
        if (load) begin
          if (col_last) begin
            state_d = StIdle;
          end else begin
            col_d = col_q + 1'b1;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      col_q   <= '0;
      wipe_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      col_q   <= col_d;
      if (in_xfer) begin
        wipe_q <= (opcode_i == OpWipe);
      end
    end
  end

  // Drawing frame: single-dot writes and a full clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PanelWidth; i++) begin
        drawing_q[i] <= '0;
      end
    end else if (in_xfer && opcode_i == OpClear) begin
      for (int i = 0; i < PanelWidth; i++) begin
        drawing_q[i] <= '0;
      end
    end else if (in_xfer && opcode_i == OpDraw && draw_hit) begin
      drawing_q[x_pos_i[ColW-1:0]][y_pos_i[RowW-1:0]] <= dot_color_i;
    end
  end

  // Shown frame: each walked column takes the new dot values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < PanelWidth; i++) begin
        shown_q[i] <= '0;
      end
    end else if (load) begin
      shown_q[col_q] <= col_res.dots;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_col_q  <= OutColW'(col_q);
      out_chg_q  <= col_res.chg;
      out_dots_q <= col_res.dots;
      out_last_q <= col_last;
      out_wipe_q <= wipe_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign column_index_o = out_col_q;
  assign change_mask_o  = OutWordW'(out_chg_q);
  assign column_dots_o  = OutWordW'(out_dots_q);
  assign last_column_o  = out_last_q;

  // A render or wipe transfer starts the walk at column zero.
  a_walk_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer && (opcode_i == OpRender || opcode_i == OpWipe)
    |=> state_q == StWalk && col_q == '0)
    else $error("walk did not start at column zero");

  // Each loaded column is followed by the next one or by the end of the walk.
  a_walk_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load && !col_last |=> col_q == $past(col_q) + 1'b1 && state_q == StWalk)
    else $error("column counter skipped or stopped early");

  // A column produced by a wipe never shows lit dots.
  a_wipe_dark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_wipe_q |-> column_dots_o == '0)
    else $error("wipe column carries lit dots");

  // The last-column flag matches the column index.
  a_last_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> last_column_o == (column_index_o == OutColW'(PanelWidth - 1)))
    else $error("last column flag disagrees with column index");

endmodule

FILE: tb/flip_dot_frame_diff_engine_core_tb.sv
// Testbench for flip_dot_frame_diff_engine_core: a directed table, then random items.
// Every flip command is checked against a predictor of the two frames kept here.
// Depends on fdd_pkg and the RTL of the engine.
`timescale 1ns / 100ps

module flip_dot_frame_diff_engine_core_tb;
  import fdd_pkg::*;

  // One expected flip command.
  typedef struct packed {
    logic [5:0]  column;
    logic [31:0] mask;
    logic [31:0] dots;
    logic        last;
  } flip_cmd_t;

  // One row of the directed table. The typed mask and dots apply to every column.
  typedef struct packed {
    opcode_t            op;
    logic signed [6:0]  x;
    logic signed [5:0]  y;
    logic               color;
    logic               typed;
    logic [31:0]        mask;
    logic [31:0]        dots;
  } stim_row_t;

  localparam int NumRows = 22;
  localparam int HoldCycles = 200;

  // Hex values for x and y below: 7'h40 is -64, 7'h7F and 6'h3F are -1, 6'h20 is -32.
  localparam stim_row_t DirRows [NumRows] = '{
    '{OpRender, 7'd0,  6'd0,  1'b0, 1'b1, 32'h0000_0000, 32'h0000_0000},
    '{OpWipe,   7'd0,  6'd0,  1'b0, 1'b1, 32'h0000_00FF, 32'h0000_0000},
    '{OpDraw,   7'd0,  6'd0,  1'b1, 1'b0, 32'h0, 32'h0},
    '{OpDraw,   7'd31, 6'd7,  1'b1, 1'b0, 32'h0, 32'h0},
    '{OpDraw,   7'h40, 6'h20, 1'b1, 1'b0, 32'h0, 32'h0},
    '{OpDraw,   7'd63, 6'd31, 1'b1, 1'b0, 32'h0, 32'h0},
    '{OpDraw,   7'd32, 6'd0,  1'b1, 1'b0, 32'h0, 32'h0},
    '{OpDraw,   7'd0,  6'd8,  1'b1, 1'b0, 32'h0, 32'h0},
    '{OpDraw,   7'h7F, 6'h3F, 1'b1, 1'b0, 32'h0, 32'h0},
    '{OpDraw,   7'd5,  6'd3,  1'b1, 1'b0, 32'h0, 32'h0},
    '{OpRender, 7'd0,  6'd0,  1'b0, 1'b0, 32'h0, 32'h0},
    '{OpRender, 7'd0,  6'd0,  1'b0, 1'b0, 32'h0, 32'h0},
    '{OpDraw,   7'd5,  6'd3,  1'b0, 1'b0, 32'h0, 32'h0},
    '{OpDraw,   7'd31, 6'd0,  1'b1, 1'b0, 32'h0, 32'h0},
    '{OpRender, 7'd0,  6'd0,  1'b0, 1'b0, 32'h0, 32'h0},
    '{OpClear,  7'd0,  6'd0,  1'b0, 1'b0, 32'h0, 32'h0},
    '{OpRender, 7'd0,  6'd0,  1'b0, 1'b0, 32'h0, 32'h0},
    '{OpDraw,   7'd10, 6'd4,  1'b1, 1'b0, 32'h0, 32'h0},
    '{OpWipe,   7'd0,  6'd0,  1'b0, 1'b1, 32'h0000_00FF, 32'h0000_0000},
    '{OpRender, 7'd0,  6'd0,  1'b0, 1'b0, 32'h0, 32'h0},
    '{OpClear,  7'd0,  6'd0,  1'b0, 1'b0, 32'h0, 32'h0},
    '{OpClear,  7'd0,  6'd0,  1'b0, 1'b0, 32'h0, 32'h0}
  };

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  opcode_t            opcode_i = OpDraw;
  logic signed [6:0]  x_pos_i = '0;
  logic signed [5:0]  y_pos_i = '0;
  logic               dot_color_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [5:0]         column_index_o;
  logic [31:0]        change_mask_o;
  logic [31:0]        column_dots_o;
  logic               last_column_o;

  // Predicted frames and the flip commands still to come.
  col_word_t  drawing_cols [PanelWidth];
  col_word_t  shown_cols [PanelWidth];
  flip_cmd_t  flips_due [$];

  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_asked = 0;
  int hold_given = 0;
  int hold_left = 0;

  flip_dot_frame_diff_engine_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .opcode_i       (opcode_i),
    .x_pos_i        (x_pos_i),
    .y_pos_i        (y_pos_i),
    .dot_color_i    (dot_color_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .column_index_o (column_index_o),
    .change_mask_o  (change_mask_o),
    .column_dots_o  (column_dots_o),
    .last_column_o  (last_column_o)
  );

  // Clock with a 12 ns period.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Updates the predicted frames for one accepted item and queues its flip commands.
  function automatic void predict_flips(opcode_t op, logic signed [6:0] x,
                                        logic signed [5:0] y, logic color);
    int xi;
    int yi;
    flip_cmd_t cmd;
    xi = x;
    yi = y;
    case (op)
      OpDraw: begin
        // Dots off the panel leave the drawing frame alone.
        if (xi >= 0 && yi >= 0 && xi < int'(PanelWidth) && yi < int'(PanelHeight)) begin
          drawing_cols[xi][yi] = color;
        end
      end
      OpClear: begin
        foreach (drawing_cols[c]) drawing_cols[c] = '0;
      end
      default: begin
        for (int c = 0; c < int'(PanelWidth); c++) begin
          cmd.column = 6'(c);
          cmd.last   = (c == int'(PanelWidth) - 1);
          if (op == OpRender) begin
            cmd.mask = drawing_cols[c] ^ shown_cols[c];
            cmd.dots = drawing_cols[c];
            shown_cols[c] = drawing_cols[c];
          end else begin
            cmd.mask = col_word_t'('1);
            cmd.dots = '0;
            shown_cols[c] = '0;
          end
          flips_due.push_back(cmd);
        end
      end
    endcase
  endfunction

  // Compares one output transfer with the oldest expected flip command.
  function automatic void check_flip();
    flip_cmd_t want;
    if (flips_due.size() == 0) begin
      $error("unexpected flip command for column %0d", column_index_o);
      fail_count++;
      return;
    end
    want = flips_due.pop_front();
    if (column_index_o !== want.column) begin
      $error("column_index: expected %0d, got %0d", want.column, column_index_o);
      fail_count++;
    end
    if (change_mask_o !== want.mask) begin
      $error("change_mask: expected %h, got %h", want.mask, change_mask_o);
      fail_count++;
    end
    if (column_dots_o !== want.dots) begin
      $error("column_dots: expected %h, got %h", want.dots, column_dots_o);
      fail_count++;
    end
    if (last_column_o !== want.last) begin
      $error("last_column: expected %0b, got %0b", want.last, last_column_o);
      fail_count++;
    end
  endfunction

  // Output side: checks each transfer, then picks the stall for the next cycle.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) check_flip();
    if (hold_left != 0) begin
      out_stall_i <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_asked != hold_given) begin
      out_stall_i <= 1'b1;
      hold_left <= HoldCycles;
      hold_given <= hold_given + 1;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // Offers one item until the transfer happens, then predicts its results.
  // A typed row overrides the predicted mask and dots of every column.
  task automatic offer_item(stim_row_t row);
    int first;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    opcode_i    <= row.op;
    x_pos_i     <= row.x;
    y_pos_i     <= row.y;
    dot_color_i <= row.color;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    first = flips_due.size();
    predict_flips(row.op, row.x, row.y, row.color);
    if (row.typed) begin
      for (int i = first; i < flips_due.size(); i++) begin
        flips_due[i].mask = row.mask;
        flips_due[i].dots = row.dots;
      end
    end
  endtask

  // Run limit.
  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  // Main sequence: reset, directed table, three random phases, drain.
  initial begin
    stim_row_t row;
    int pick;
    foreach (drawing_cols[c]) drawing_cols[c] = '0;
    foreach (shown_cols[c]) shown_cols[c] = '0;
    send_idle_pct  = 26;
    recv_stall_pct = 71;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NumRows; i++) offer_item(DirRows[i]);

    // Mostly on-panel draws so the frames fill up; some draws span the full field range.
    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        send_idle_pct  = 71;
        recv_stall_pct = 26;
      end else if (phase == 2) begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Long hold-off on the output while items keep coming.
        hold_asked = hold_asked + 1;
      end
      for (int k = 0; k < 26; k++) begin
        pick = $urandom_range(99);
        row = '0;
        row.color = 1'($urandom);
        if (pick < 55) begin
          row.op = OpDraw;
          row.x  = 7'($urandom_range(PanelWidth - 1));
          row.y  = 6'($urandom_range(PanelHeight - 1));
        end else if (pick < 65) begin
          row.op = OpDraw;
          row.x  = 7'($urandom);
          row.y  = 6'($urandom);
        end else if (pick < 72) begin
          row.op = OpClear;
        end else if (pick < 92) begin
          row.op = OpRender;
        end else begin
          row.op = OpWipe;
        end
        offer_item(row);
      end
    end
    in_valid_i <= 1'b0;

    while (flips_due.size() != 0) @(posedge clk_i);
    repeat (PanelWidth + 8) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/fdd_pkg.sv
rtl/fdd_col_unit.sv
rtl/flip_dot_frame_diff_engine_core.sv
tb/flip_dot_frame_diff_engine_core_tb.sv
